// ----- rtl/core/jss_pkg.sv -----
// Shared types and codes for the jump search sorted table core.
`timescale 1ns / 1ps

package jss_pkg;

    // Request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    // Result status codes
    typedef enum logic [1:0] {
        ST_APPENDED = 2'd0,
        ST_FULL     = 2'd1,
        ST_SEARCHED = 2'd2,
        ST_CLEARED  = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQRT,
        S_JUMP,
        S_SCAN,
        S_EMIT
    } t_state;

    // Input word
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] data_value;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic       found;
        logic [9:0] found_index;
        logic [1:0] status;
    } t_out_word;

endpackage

// ----- rtl/core/jss_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module jss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/jss_isqrt.sv -----
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module jss_isqrt #(
    parameter int N_WIDTH = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [N_WIDTH-1:0]         i_n,
    output logic                       o_done,
    output logic [(N_WIDTH+1)/2-1:0]   o_root
);

    localparam int RW = (N_WIDTH + 1) / 2;
    localparam int SW = 2 * RW;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [RW-1:0] r_root, n_root;
    logic [RW-1:0] r_bit, n_bit;
    logic [N_WIDTH-1:0] r_n, n_n;
    logic [RW-1:0] cand;
    logic [SW-1:0] cand_sq;

    // trial bit squared against the operand
    assign cand    = r_root | r_bit;
    assign cand_sq = cand * cand;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_root = r_root;
        n_bit  = r_bit;
        n_n    = r_n;
        if (i_start) begin
            n_busy = 1'b1;
            n_root = '0;
            n_bit  = RW'(1) << (RW - 1);
            n_n    = i_n;
        end else if (r_busy) begin
            if (cand_sq <= SW'(r_n)) begin
                n_root = cand;
            end
            n_bit = r_bit >> 1;
            if (r_bit[0]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_root <= n_root;
        r_bit  <= n_bit;
        r_n    <= n_n;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- rtl/core/jump_search_sorted_table_core.sv -----
// Top level: jump search table with element store, sequencer and shared compare unit.
//
// Use: one input channel (i_in_valid / o_in_ready / i_in_word) takes requests:
// append an element, search for a key, or clear the store. One output channel
// (o_out_valid / i_out_ready / o_out_word) returns one result word per request;
// req_type 3 is taken and dropped without a result.
// Elements are expected to be appended in ascending signed order.
// Append and clear go straight from acceptance to the hand-off state.
// A search of a store of n elements with block size s = floor(sqrt(n)) first
// runs the square root, then jumps block by block until a block end reaches the
// key (a miss when none does), then scans that block element by element (a miss
// when no element matches), and then hands off. The store read port sets the
// jump and scan rate; block end and scan reads are issued every cycle and
// compared in the next cycle in the shared subtract unit.
// A search of an empty store goes straight to hand-off.
// The block takes one request at a time; o_in_ready is high in idle.
// A finished result waits in the output register while the next request is
// taken; a stalled receiver only holds the sequencer at hand-off.
// Reset empties the store (count to zero); store contents are not cleared.
`timescale 1ns / 1ps

module jump_search_sorted_table_core #(
    parameter int MAX_LEN    = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  jss_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output jss_pkg::t_out_word  o_out_word
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int RW = (CW + 1) / 2;
    localparam int DW = DATA_WIDTH;

    jss_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [DW-1:0]      r_key, n_key;
    logic [RW-1:0]      r_step, n_step;
    logic [CW:0]        r_iss_start, n_iss_start;
    logic [CW:0]        r_iss_end, n_iss_end;
    logic [CW-1:0]      r_scan_end, n_scan_end;
    logic               r_p_vld, n_p_vld;
    logic [CW-1:0]      r_p_start, n_p_start;
    logic [CW-1:0]      r_p_end, n_p_end;
    jss_pkg::t_out_word r_res, n_res;
    logic               r_out_vld, n_out_vld;
    jss_pkg::t_out_word r_out, n_out;

    logic [63:0]        in_ext;
    logic [DW-1:0]      in_val;
    logic               ram_we;
    logic [DW-1:0]      rd_data;
    logic [CW:0]        rd_addr;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [RW-1:0]      sqrt_root;
    logic [CW:0]        count_ext;
    logic [CW:0]        jump_end_c;
    logic               jump_more;
    logic               scan_more;
    logic [DW:0]        cmp_diff;
    logic               cmp_le;
    logic               cmp_eq;

    // sign-extend the 32-bit word, then keep DATA_WIDTH bits
    assign in_ext = {{32{i_in_word.data_value[31]}}, i_in_word.data_value};
    assign in_val = in_ext[DW-1:0];

    // element store
    jss_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (in_val),
        .i_raddr (rd_addr[AW-1:0]),
        .o_rdata (rd_data)
    );

    // block size unit
    jss_isqrt #(
        .N_WIDTH (CW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_n     (r_count),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // shared compare unit: element minus key
    assign cmp_diff = {rd_data[DW-1], rd_data} - {r_key[DW-1], r_key};
    assign cmp_le   = ~cmp_diff[DW];
    assign cmp_eq   = (cmp_diff == '0);

    // block end clamped to the count, and loop conditions
    assign count_ext  = {1'b0, r_count};
    assign jump_end_c = (r_iss_end > count_ext) ? count_ext : r_iss_end;
    assign jump_more  = (r_iss_start < count_ext);
    assign scan_more  = (r_iss_start < {1'b0, r_scan_end});
    assign rd_addr    = (r_state == jss_pkg::S_JUMP) ? (jump_end_c - (CW + 1)'(1)) : r_iss_start;

    // sequencer next state and outputs
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_key       = r_key;
        n_step      = r_step;
        n_iss_start = r_iss_start;
        n_iss_end   = r_iss_end;
        n_scan_end  = r_scan_end;
        n_p_vld     = r_p_vld;
        n_p_start   = r_p_start;
        n_p_end     = r_p_end;
        n_res       = r_res;
        n_out       = r_out;
        n_out_vld   = r_out_vld;
        ram_we      = 1'b0;
        sqrt_start  = 1'b0;
        o_in_ready  = 1'b0;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            jss_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_res.found       = 1'b0;
                    n_res.found_index = '0;
                    case (i_in_word.req_type)
                        jss_pkg::REQ_APPEND: begin
                            if (r_count < CW'(MAX_LEN)) begin
                                ram_we       = 1'b1;
                                n_count      = r_count + CW'(1);
                                n_res.status = jss_pkg::ST_APPENDED;
                            end else begin
                                n_res.status = jss_pkg::ST_FULL;
                            end
                            n_state = jss_pkg::S_EMIT;
                        end
                        jss_pkg::REQ_SEARCH: begin
                            n_key        = in_val;
                            n_res.status = jss_pkg::ST_SEARCHED;
                            if (r_count == '0) begin
                                n_state = jss_pkg::S_EMIT;
                            end else begin
                                sqrt_start = 1'b1;
                                n_state    = jss_pkg::S_SQRT;
                            end
                        end
                        jss_pkg::REQ_CLEAR: begin
                            n_count      = '0;
                            n_res.status = jss_pkg::ST_CLEARED;
                            n_state      = jss_pkg::S_EMIT;
                        end
                        default: begin
                            n_state = jss_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            jss_pkg::S_SQRT: begin
                if (sqrt_done) begin
                    n_step      = sqrt_root;
                    n_iss_start = '0;
                    n_iss_end   = (CW + 1)'(sqrt_root);
                    n_p_vld     = 1'b0;
                    n_state     = jss_pkg::S_JUMP;
                end
            end
            jss_pkg::S_JUMP: begin
                // issue the next block end read speculatively
                n_p_vld = jump_more;
                if (jump_more) begin
                    n_p_start   = r_iss_start[CW-1:0];
                    n_p_end     = jump_end_c[CW-1:0];
                    n_iss_start = jump_end_c;
                    n_iss_end   = jump_end_c + (CW + 1)'(r_step);
                end
                // check the previous block end against the key
                if (r_p_vld && cmp_le) begin
                    n_iss_start = {1'b0, r_p_start};
                    n_scan_end  = r_p_end;
                    n_p_vld     = 1'b0;
                    n_state     = jss_pkg::S_SCAN;
                end else if (!r_p_vld && !jump_more) begin
                    n_state = jss_pkg::S_EMIT;
                end
            end
            jss_pkg::S_SCAN: begin
                // issue one element read a cycle, check the one before
                n_p_vld = scan_more;
                if (scan_more) begin
                    n_p_start   = r_iss_start[CW-1:0];
                    n_iss_start = r_iss_start + (CW + 1)'(1);
                end
                if (r_p_vld && cmp_eq) begin
                    n_res.found       = 1'b1;
                    n_res.found_index = 10'(r_p_start);
                    n_p_vld           = 1'b0;
                    n_state           = jss_pkg::S_EMIT;
                end else if (!r_p_vld && !scan_more) begin
                    n_state = jss_pkg::S_EMIT;
                end
            end
            jss_pkg::S_EMIT: begin
                // hand the result word to the output register
                if (!r_out_vld || i_out_ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = jss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = jss_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= jss_pkg::S_IDLE;
            r_count   <= '0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_p_vld   <= n_p_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_step      <= n_step;
        r_iss_start <= n_iss_start;
        r_iss_end   <= n_iss_end;
        r_scan_end  <= n_scan_end;
        r_p_start   <= n_p_start;
        r_p_end     <= n_p_end;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the jump search sorted table core.
`timescale 1ns / 1ps

module tb_top;

    localparam int                 MAX_LEN     = 1024;
    localparam int                 CYCLE_LIMIT = 1_000_000;
    localparam logic [1:0]         REQ_UNUSED  = 2'd3;
    localparam logic signed [31:0] VAL_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX     = 32'sh7FFF_FFFF;

    // Idle modes, rotated as words are taken
    typedef enum int {
        IDLE_NONE,
        IDLE_TX,
        IDLE_RX,
        IDLE_BOTH
    } t_idle_mode;

    // A word waiting to be offered; drain_first holds it until all answers are in
    typedef struct {
        jss_pkg::t_in_word word;
        bit                drain_first;
    } t_pending;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    jss_pkg::t_in_word  i_in_word   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    jss_pkg::t_out_word o_out_word;

    t_pending           pending_words[$];
    jss_pkg::t_out_word answers_due[$];

    // Shadow of the block's store
    logic signed [31:0] shadow_mem [MAX_LEN];
    int unsigned        shadow_count = 0;

    // Generator-side view of the store, used to pick search keys
    logic signed [31:0] gen_vals[$];
    longint             gen_last;
    bit                 drain_next;
    bit                 counting_random;
    int                 rand_items;

    int                 words_taken = 0;
    int                 err_count   = 0;
    int                 cycle_count = 0;
    int                 hold_left   = 0;
    int                 hold_mark   = 300;
    bit                 gives;
    jss_pkg::t_out_word answer;
    jss_pkg::t_out_word due;

    jump_search_sorted_table_core #(
        .MAX_LEN    (MAX_LEN),
        .DATA_WIDTH (32)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #1 i_clk = ~i_clk;

    // Jump search over the shadow store: block size floor(sqrt(count))
    function automatic void jump_lookup(input logic signed [31:0] key, output bit hit,
                                        output int unsigned pos);
        int unsigned n;
        int unsigned blk;
        int unsigned lo;
        int unsigned hi;
        hit = 1'b0;
        pos = 0;
        n   = shadow_count;
        if (n == 0) return;
        blk = 0;
        while ((blk + 1) * (blk + 1) <= n) blk++;
        lo = 0;
        hi = blk;
        while (lo < n) begin
            if (hi > n) hi = n;
            if (key <= shadow_mem[hi - 1]) begin
                for (int unsigned i = lo; i < hi; i++) begin
                    if (shadow_mem[i] == key) begin
                        hit = 1'b1;
                        pos = i;
                        return;
                    end
                end
                return;
            end
            lo = hi;
            hi = hi + blk;
        end
    endfunction

    // Apply one request to the shadow state; gives is low when no answer follows
    function automatic void apply_request(input jss_pkg::t_in_word w, output bit gives_o,
                                          output jss_pkg::t_out_word ans);
        bit          hit;
        int unsigned pos;
        gives_o = 1'b1;
        ans     = '0;
        case (w.req_type)
            jss_pkg::REQ_APPEND: begin
                if (shadow_count < MAX_LEN) begin
                    shadow_mem[shadow_count] = w.data_value;
                    shadow_count++;
                    ans.status = jss_pkg::ST_APPENDED;
                end else begin
                    ans.status = jss_pkg::ST_FULL;
                end
            end
            jss_pkg::REQ_SEARCH: begin
                jump_lookup(w.data_value, hit, pos);
                ans.found       = hit;
                ans.found_index = pos[9:0];
                ans.status      = jss_pkg::ST_SEARCHED;
            end
            jss_pkg::REQ_CLEAR: begin
                shadow_count = 0;
                ans.status   = jss_pkg::ST_CLEARED;
            end
            default: begin
                gives_o = 1'b0;
            end
        endcase
    endfunction

    function automatic int idle_pct(input bit rx_side);
        t_idle_mode mode;
        mode = t_idle_mode'((words_taken / 150) % 4);
        case (mode)
            IDLE_TX:   return rx_side ? 0 : 86;
            IDLE_RX:   return rx_side ? 86 : 0;
            IDLE_BOTH: return 26;
            default:   return 0;
        endcase
    endfunction

    task automatic queue_word(input logic [1:0] req, input logic signed [31:0] val);
        t_pending p;
        p.word.req_type   = req;
        p.word.data_value = val;
        p.drain_first     = drain_next;
        drain_next        = 1'b0;
        pending_words.push_back(p);
        if (counting_random && req != REQ_UNUSED) rand_items++;
    endtask

    // Rising appends with random steps, a little noise mixed in
    task automatic append_ascending(input int n, input int unsigned step_max);
        longint             nxt;
        logic signed [31:0] junk;
        repeat (n) begin
            nxt = gen_last + longint'($urandom_range(0, step_max));
            if (nxt > longint'(VAL_MAX)) nxt = longint'(VAL_MAX);
            gen_last = nxt;
            queue_word(jss_pkg::REQ_APPEND, 32'(nxt));
            if (gen_vals.size() < MAX_LEN) gen_vals.push_back(32'(nxt));
            if ($urandom_range(0, 99) < 2) begin
                junk = $urandom();
                queue_word(jss_pkg::REQ_APPEND, junk);
                if (gen_vals.size() < MAX_LEN) gen_vals.push_back(junk);
            end else if ($urandom_range(0, 99) < 2) begin
                queue_word(REQ_UNUSED, $urandom());
            end
        end
    endtask

    // Searches: hits, near misses, keys past the end, extremes and random keys
    task automatic search_mix(input int m);
        int                 pick;
        logic signed [31:0] key;
        repeat (m) begin
            pick = $urandom_range(0, 99);
            if (gen_vals.size() != 0 && pick < 50) begin
                key = gen_vals[$urandom_range(0, gen_vals.size() - 1)];
            end else if (gen_vals.size() != 0 && pick < 65) begin
                key = gen_vals[$urandom_range(0, gen_vals.size() - 1)] + 1;
            end else if (gen_vals.size() != 0 && pick < 72) begin
                key = gen_vals[$] + 1 + $urandom_range(0, 1000);
            end else if (pick < 82) begin
                key = pick[0] ? VAL_MAX : VAL_MIN;
            end else begin
                key = $urandom();
            end
            queue_word(jss_pkg::REQ_SEARCH, key);
            if ($urandom_range(0, 99) < 4) queue_word(REQ_UNUSED, $urandom());
        end
    endtask

    // Stimulus, reset and end of run
    initial begin
        int seq_idx;
        int n;
        drain_next      = 1'b0;
        counting_random = 1'b0;
        rand_items      = 0;
        gen_last        = longint'(VAL_MIN);

        // Directed: empty store, extremes, key past every block end, unsorted, unused code
        queue_word(jss_pkg::REQ_SEARCH, 0);
        queue_word(REQ_UNUSED, VAL_MAX);
        queue_word(jss_pkg::REQ_APPEND, VAL_MIN);
        queue_word(jss_pkg::REQ_APPEND, -5);
        queue_word(jss_pkg::REQ_APPEND, 0);
        queue_word(jss_pkg::REQ_APPEND, 7);
        queue_word(jss_pkg::REQ_APPEND, 7);
        queue_word(jss_pkg::REQ_APPEND, VAL_MAX);
        queue_word(jss_pkg::REQ_SEARCH, VAL_MIN);
        queue_word(jss_pkg::REQ_SEARCH, VAL_MAX);
        queue_word(jss_pkg::REQ_SEARCH, 7);
        queue_word(jss_pkg::REQ_SEARCH, 3);
        queue_word(jss_pkg::REQ_CLEAR, '1);
        queue_word(jss_pkg::REQ_APPEND, 1);
        queue_word(jss_pkg::REQ_APPEND, 2);
        queue_word(jss_pkg::REQ_APPEND, 3);
        queue_word(jss_pkg::REQ_SEARCH, 100);
        queue_word(jss_pkg::REQ_SEARCH, 2);
        queue_word(jss_pkg::REQ_APPEND, 50);
        queue_word(jss_pkg::REQ_APPEND, 10);
        queue_word(jss_pkg::REQ_SEARCH, 10);
        queue_word(jss_pkg::REQ_SEARCH, 50);
        queue_word(jss_pkg::REQ_CLEAR, 0);
        queue_word(jss_pkg::REQ_SEARCH, 1);
        queue_word(REQ_UNUSED, -1);

        // Random sequences: mostly sorted fills followed by searches
        counting_random = 1'b1;
        seq_idx         = 0;
        while (rand_items < 1400) begin
            if (seq_idx == 3) begin
                // Fill the store to capacity, overflow it, then search it
                queue_word(jss_pkg::REQ_CLEAR, $urandom());
                gen_vals.delete();
                gen_last = longint'(VAL_MIN) + $urandom_range(0, 100000);
                append_ascending(MAX_LEN + 3, 4_000_000);
                queue_word(jss_pkg::REQ_SEARCH, gen_vals[0]);
                queue_word(jss_pkg::REQ_SEARCH, gen_vals[MAX_LEN - 1]);
                queue_word(jss_pkg::REQ_SEARCH, gen_vals[511]);
                queue_word(jss_pkg::REQ_SEARCH, gen_vals[512]);
                search_mix(36);
                drain_next = 1'b1;
            end else if ($urandom_range(0, 99) < 15) begin
                // Noise: any request code, any value
                repeat ($urandom_range(1, 20)) begin
                    queue_word(2'($urandom_range(0, 3)), $urandom());
                end
                gen_vals.delete();
                queue_word(jss_pkg::REQ_CLEAR, $urandom());
                gen_last = int'($urandom());
            end else begin
                if (gen_vals.size() > 900 || $urandom_range(0, 99) < 75) begin
                    queue_word(jss_pkg::REQ_CLEAR, $urandom());
                    gen_vals.delete();
                    gen_last = ($urandom_range(0, 9) == 0) ? longint'(VAL_MIN)
                                                           : longint'(int'($urandom()));
                end
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 200)
                                                : $urandom_range(0, 30);
                append_ascending(n, 1 << $urandom_range(0, 26));
                search_mix($urandom_range(1, 12));
                if ($urandom_range(0, 3) == 0) begin
                    append_ascending($urandom_range(1, 5), 1 << $urandom_range(0, 20));
                    search_mix(3);
                end
                if ($urandom_range(0, 9) == 0) drain_next = 1'b1;
            end
            seq_idx++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_in_valid || answers_due.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_count == 0) begin
            $display("jump_search_sorted_table_core regression: pass");
        end else begin
            $display("jump_search_sorted_table_core regression: fail");
        end
        $finish;
    end

    // Request driver: holds a word until taken, then offers the next or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_words.size() != 0
                && !(pending_words[0].drain_first
                     && (answers_due.size() != 0 || i_in_valid))
                && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                i_in_word  <= pending_words[0].word;
                i_in_valid <= 1'b1;
                void'(pending_words.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus a long hold-off every 800 words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (words_taken >= hold_mark) begin
            hold_left   <= 400;
            hold_mark   <= hold_mark + 800;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    // Compare each result word with the oldest answer due, then record new requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    $error("result word with no request pending: status %0d",
                           o_out_word.status);
                    err_count++;
                end else begin
                    due = answers_due.pop_front();
                    if (o_out_word.found !== due.found) begin
                        $error("found: expected %0d, actual %0d",
                               due.found, o_out_word.found);
                        err_count++;
                    end
                    if (o_out_word.found_index !== due.found_index) begin
                        $error("found_index: expected %0d, actual %0d",
                               due.found_index, o_out_word.found_index);
                        err_count++;
                    end
                    if (o_out_word.status !== due.status) begin
                        $error("status: expected %0d, actual %0d",
                               due.status, o_out_word.status);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                apply_request(i_in_word, gives, answer);
                if (gives) answers_due.push_back(answer);
                words_taken <= words_taken + 1;
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("jump_search_sorted_table_core regression: fail");
            $finish;
        end
    end

endmodule

// ----- files.f -----
rtl/core/jss_pkg.sv
rtl/core/jss_ram.sv
rtl/core/jss_isqrt.sv
rtl/core/jump_search_sorted_table_core.sv
dv/tb_top.sv
